/* rtl/rrt_tree_extend_3d_core_assert.svh */
// assertion macros for the rrt tree extend core
// needs clk and arst_n in the scope of the module that uses them
`ifndef RRT_TREE_EXTEND_3D_CORE_ASSERT_SVH
`define RRT_TREE_EXTEND_3D_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RRT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rrt3d_pkg.sv */
// shared types, constants and obstacle test for the rrt tree extend core
// no dependencies
package rrt3d_pkg;

	localparam int MAX_NODES           = 4096;
	localparam int NUM_BOXES           = 3;
	localparam int FRAC_BITS           = 8;
	localparam int MAX_SEGMENT_SAMPLES = 11;

	localparam int IDX_W   = $clog2(MAX_NODES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int X_W     = 15;
	localparam int Z_W     = 13;
	localparam int COST_W  = 24;
	localparam int CFG_W   = 17;
	localparam int BIAS_W  = 16;
	localparam int BUDG_W  = 12;
	localparam int SQ_W    = 32;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int DIV_N_W = 26;
	localparam int DIV_D_W = ROOT_W;
	localparam int SEG_I_W = $clog2(MAX_SEGMENT_SAMPLES);

	localparam int ONE_M    = 1 << FRAC_BITS;
	localparam int STEP_LEN = 5 * ONE_M;
	localparam int INFLATE  = 3 * (ONE_M / 2);
	localparam int REACH_SQ = STEP_LEN * STEP_LEN;
	localparam int STEP_W   = $clog2(STEP_LEN + 1);

	// obstacle boxes in whole metres: xmin, ymin, zmin, xmax, ymax, zmax
	localparam int BOX_M [NUM_BOXES][6] = '{
		'{20, 20, 0, 40, 40, 25},
		'{60, 50, 0, 75, 70, 30},
		'{45, 10, 0, 55, 60, 15}
	};

	typedef enum logic [2:0] {
		ST_REJECT = 3'd0,
		ST_ADDED  = 3'd1,
		ST_GOAL   = 3'd2,
		ST_FAIL   = 3'd3,
		ST_WAYPT  = 3'd4,
		ST_RESET  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KIND_RESET  = 2'd0,
		KIND_EXTEND = 2'd1,
		KIND_TRACE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_START_X = 3'd0,
		CFG_START_Y = 3'd1,
		CFG_START_Z = 3'd2,
		CFG_GOAL_X  = 3'd3,
		CFG_GOAL_Y  = 3'd4,
		CFG_GOAL_Z  = 3'd5,
		CFG_BIAS    = 3'd6,
		CFG_BUDGET  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [X_W-1:0] y;
		logic [Z_W-1:0] z;
	} pt_t;

	typedef struct packed {
		pt_t               p;
		logic [IDX_W-1:0]  parent;
		logic [COST_W-1:0] cost;
	} node_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  idx;
		pt_t               p;
		logic [COST_W-1:0] cost;
		logic              last;
	} res_t;

	// point against every inflated box, bounds included
	function automatic logic in_any_box(input pt_t p);
		int   x;
		int   y;
		int   z;
		logic hit;
		x   = int'(p.x);
		y   = int'(p.y);
		z   = int'(p.z);
		hit = 1'b0;
		for (int b = 0; b < NUM_BOXES; b++) begin
			if (x >= BOX_M[b][0] * ONE_M - INFLATE && x <= BOX_M[b][3] * ONE_M + INFLATE &&
			    y >= BOX_M[b][1] * ONE_M - INFLATE && y <= BOX_M[b][4] * ONE_M + INFLATE &&
			    z >= BOX_M[b][2] * ONE_M - INFLATE && z <= BOX_M[b][5] * ONE_M + INFLATE) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic logic [COST_W-1:0] cost_sat(input logic [COST_W-1:0] c,
	                                               input logic [ROOT_W-1:0] d);
		logic [COST_W:0] s;
		s = {1'b0, c} + (COST_W+1)'(d);
		return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
	endfunction

endpackage

/* rtl/rrt3d_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rrt3d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/rrt_tree_extend_3d_core.sv */
// top level of the 3-d rrt tree extend core: sequencer, distance pipe, isqrt, divider
// depends on rrt3d_pkg, rrt3d_ram and rrt_tree_extend_3d_core_assert.svh
//
// One beat in gives one beat out (kind 3 gives none). The tree lives in one ram of
// MAX_NODES entries holding position, parent and cost; entries are only read after they
// were written, so there is no clearing pass and a reset beat (kind 0) is needed before
// extending. An extend streams every stored node through the ram read port at one node
// per cycle into a three-stage squared-distance pipe, then uses a 16-step integer square
// root and a 26-step restoring divider, one per coordinate, to steer and to interpolate
// the collision samples (up to 11 per segment, two segments when the goal is in reach).
// Only one beat is worked on at a time; in_stall is high while it runs, and a finished
// result waits in the output register while the next beat is taken.
`include "rrt_tree_extend_3d_core_assert.svh"

module rrt_tree_extend_3d_core import rrt3d_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// config write port
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	// input beat
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [X_W-1:0]    sample_x,
	input  logic [X_W-1:0]    sample_y,
	input  logic [Z_W-1:0]    sample_z,
	input  logic [BIAS_W-1:0] bias_draw,
	// result beat
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [IDX_W-1:0]  node_index,
	output logic [X_W-1:0]    node_x,
	output logic [X_W-1:0]    node_y,
	output logic [Z_W-1:0]    node_z,
	output logic [COST_W-1:0] path_cost,
	output logic              last_waypoint
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_NEAR_RD,
		S_NEAR_WAIT,
		S_STEER_SQRT,
		S_STEER_DIV,
		S_DIST_WAIT,
		S_COST_SQRT,
		S_SEG_DIV,
		S_SEG_CHK,
		S_GOAL_SQRT,
		S_TRACE_RD,
		S_TRACE_WAIT,
		S_RESULT
	} state_t;

	// configuration registers
	pt_t               start_q;
	pt_t               goal_q;
	logic [CFG_W-1:0]  goal_bias_q;
	logic [BUDG_W-1:0] budget_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '{x: X_W'(1280), y: X_W'(1280), z: Z_W'(1280)};
			goal_q      <= '{x: X_W'(23040), y: X_W'(23040), z: Z_W'(5120)};
			goal_bias_q <= CFG_W'(6554);
			budget_q    <= BUDG_W'(3000);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_START_X: start_q.x   <= cfg_wdata[X_W-1:0];
				CFG_START_Y: start_q.y   <= cfg_wdata[X_W-1:0];
				CFG_START_Z: start_q.z   <= cfg_wdata[Z_W-1:0];
				CFG_GOAL_X:  goal_q.x    <= cfg_wdata[X_W-1:0];
				CFG_GOAL_Y:  goal_q.y    <= cfg_wdata[X_W-1:0];
				CFG_GOAL_Z:  goal_q.z    <= cfg_wdata[Z_W-1:0];
				CFG_BIAS:    goal_bias_q <= cfg_wdata;
				CFG_BUDGET:  budget_q    <= cfg_wdata[BUDG_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer registers
	state_t             state_q;
	logic [CNT_W-1:0]   node_count_q;
	logic [BUDG_W-1:0]  attempt_q;
	logic               solved_q;
	logic               trace_done_q;
	logic [IDX_W-1:0]   trace_ptr_q;
	logic [CNT_W-1:0]   scan_q;
	pt_t                smp_q;
	pt_t                nearp_q;
	pt_t                np_q;
	pt_t                pa_q;
	pt_t                pb_q;
	pt_t                pt_q;
	pt_t                seg_a_q;
	pt_t                seg_b_q;
	logic [SEG_I_W-1:0] seg_i_q;
	logic [SEG_I_W-1:0] seg_steps_q;
	logic               seg_goal_q;
	logic               dist_goal_q;
	logic [1:0]         comp_q;
	logic [ROOT_W-1:0]  d_q;
	logic [ROOT_W-1:0]  g_q;
	logic [COST_W-1:0]  base_cost_q;
	logic [COST_W-1:0]  ncost_q;
	logic [IDX_W-1:0]   idx_q;
	res_t               res_q;
	res_t               out_q;
	logic               out_valid_q;
	logic               dv_go_q;
	logic               sq_go_q;
	logic [SQ_W-1:0]    sq_in_q;
	logic               dist_go_q;
	logic               wr_q;
	logic [IDX_W-1:0]   waddr_q;
	node_t              wdata_q;

	// nearest-node search results
	logic [SQ_W-1:0]    best_q;
	logic [IDX_W-1:0]   near_q;

	// node store
	logic [IDX_W-1:0]   raddr;
	node_t              ram_rd;

	always_comb begin
		case (state_q)
			S_SCAN:    raddr = scan_q[IDX_W-1:0];
			S_NEAR_RD: raddr = near_q;
			default:   raddr = trace_ptr_q;
		endcase
	end

	// the sequencer never reads an entry in the cycle it is written, so no bypass is needed
	rrt3d_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (MAX_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (wr_q),
		.waddr (waddr_q),
		.wdata (wdata_q),
		.raddr (raddr),
		.rdata (ram_rd)
	);

	// squared-distance pipe: ram or pa_q against pb_q, diff, square, sum
	logic                rd_v_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                v_s2;
	logic                v_s3;
	logic [IDX_W-1:0]    idx_s2;
	logic [IDX_W-1:0]    idx_s3;
	logic signed [15:0]  dx_s2;
	logic signed [15:0]  dy_s2;
	logic signed [13:0]  dz_s2;
	logic [29:0]         sqx_s3;
	logic [29:0]         sqy_s3;
	logic [29:0]         sqz_s3;
	pt_t                 dist_a;
	logic [SQ_W-1:0]     dsum;

	assign dist_a = dist_go_q ? pa_q : ram_rd.p;
	assign dsum   = SQ_W'(sqx_s3) + SQ_W'(sqy_s3) + SQ_W'(sqz_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			rd_v_q <= (state_q == S_SCAN) && (scan_q < node_count_q);
			v_s2   <= rd_v_q || dist_go_q;
			v_s3   <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= scan_q[IDX_W-1:0];
		idx_s2   <= rd_idx_q;
		idx_s3   <= idx_s2;
		dx_s2    <= $signed({1'b0, dist_a.x}) - $signed({1'b0, pb_q.x});
		dy_s2    <= $signed({1'b0, dist_a.y}) - $signed({1'b0, pb_q.y});
		dz_s2    <= $signed({1'b0, dist_a.z}) - $signed({1'b0, pb_q.z});
		sqx_s3   <= 30'(32'(dx_s2) * 32'(dx_s2));
		sqy_s3   <= 30'(32'(dy_s2) * 32'(dy_s2));
		sqz_s3   <= 30'(32'(dz_s2) * 32'(dz_s2));
		// strict compare keeps the lowest index on ties
		if (state_q == S_SCAN && v_s3 && (idx_s3 == '0 || dsum < best_q)) begin
			best_q <= dsum;
			near_q <= idx_s3;
		end
	end

	// integer square root, one result bit per cycle
	logic [SQ_W-1:0]   sq_v_q;
	logic [SQ_W-1:0]   sq_r_q;
	logic [SQ_W-1:0]   sq_bit_q;
	logic              sq_busy_q;
	logic              sq_done_q;
	logic [SQ_W:0]     sq_trial;
	logic [ROOT_W-1:0] sq_root;

	assign sq_trial = {1'b0, sq_r_q} + {1'b0, sq_bit_q};
	assign sq_root  = sq_r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
		end else begin
			sq_done_q <= 1'b0;
			if (sq_go_q) begin
				sq_busy_q <= 1'b1;
			end else if (sq_busy_q && sq_bit_q == SQ_W'(1)) begin
				sq_busy_q <= 1'b0;
				sq_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sq_go_q) begin
			sq_v_q   <= sq_in_q;
			sq_r_q   <= '0;
			sq_bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (sq_busy_q) begin
			if ({1'b0, sq_v_q} >= sq_trial) begin
				sq_v_q <= sq_v_q - sq_trial[SQ_W-1:0];
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// operands of the coordinate division: steer or segment sample
	pt_t                  div_pa;
	pt_t                  div_pb;
	logic [X_W-1:0]       div_ac;
	logic [X_W-1:0]       div_bc;
	logic signed [X_W+1:0] div_diff;
	logic                 div_neg;
	logic [X_W:0]         div_mag;
	logic [DIV_N_W-1:0]   div_num;
	logic [DIV_D_W-1:0]   div_den;
	logic [X_W:0]         div_q;
	logic signed [X_W+1:0] div_sum;
	logic [X_W-1:0]       div_res;

	always_comb begin
		if (state_q == S_STEER_DIV) begin
			div_pa  = nearp_q;
			div_pb  = smp_q;
			div_den = d_q;
		end else begin
			div_pa  = seg_a_q;
			div_pb  = seg_b_q;
			div_den = DIV_D_W'(seg_steps_q);
		end
		case (comp_q)
			2'd0:    begin div_ac = div_pa.x; div_bc = div_pb.x; end
			2'd1:    begin div_ac = div_pa.y; div_bc = div_pb.y; end
			default: begin div_ac = X_W'(div_pa.z); div_bc = X_W'(div_pb.z); end
		endcase
		div_diff = $signed({2'b00, div_bc}) - $signed({2'b00, div_ac});
		div_neg  = div_diff[X_W+1];
		div_mag  = div_neg ? (X_W+1)'(-div_diff) : div_diff[X_W:0];
		if (state_q == S_STEER_DIV) begin
			div_num = DIV_N_W'(div_mag) * DIV_N_W'(STEP_LEN);
		end else begin
			div_num = DIV_N_W'(div_mag) * DIV_N_W'(seg_i_q);
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [DIV_N_W-1:0]         dv_quo_q;
	logic [DIV_D_W-1:0]         dv_rem_q;
	logic [DIV_D_W-1:0]         dv_den_q;
	logic [$clog2(DIV_N_W+1)-1:0] dv_cnt_q;
	logic                       dv_busy_q;
	logic                       dv_done_q;
	logic [DIV_D_W:0]           dv_trial;
	logic                       dv_ge;

	assign dv_trial = {dv_rem_q, dv_quo_q[DIV_N_W-1]};
	assign dv_ge    = dv_trial >= {1'b0, dv_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_done_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else begin
			dv_done_q <= 1'b0;
			if (dv_go_q) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q  <= ($clog2(DIV_N_W+1))'(DIV_N_W);
			end else if (dv_busy_q) begin
				dv_cnt_q <= dv_cnt_q - 1'b1;
				if (dv_cnt_q == 1) begin
					dv_busy_q <= 1'b0;
					dv_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv_go_q) begin
			dv_quo_q <= div_num;
			dv_rem_q <= '0;
			dv_den_q <= div_den;
		end else if (dv_busy_q) begin
			dv_rem_q <= dv_ge ? DIV_D_W'(dv_trial - {1'b0, dv_den_q}) : dv_trial[DIV_D_W-1:0];
			dv_quo_q <= {dv_quo_q[DIV_N_W-2:0], dv_ge};
		end
	end

	// quotient back onto the start coordinate, truncated toward zero
	assign div_q   = dv_quo_q[X_W:0];
	assign div_sum = div_neg ? $signed({2'b00, div_ac}) - $signed({1'b0, div_q})
	                         : $signed({2'b00, div_ac}) + $signed({1'b0, div_q});
	assign div_res = div_sum[X_W-1:0];

	// sample count of a segment from its length: half-metre spacing, clamped
	function automatic logic [SEG_I_W-1:0] steps_of(input logic [ROOT_W-1:0] d);
		logic [ROOT_W-1:0] s;
		s = d >> (FRAC_BITS - 1);
		if (s < ROOT_W'(2)) begin
			return SEG_I_W'(2);
		end else if (s > ROOT_W'(MAX_SEGMENT_SAMPLES - 1)) begin
			return SEG_I_W'(MAX_SEGMENT_SAMPLES - 1);
		end
		return s[SEG_I_W-1:0];
	endfunction

	logic in_acc;
	logic extend_ok;
	pt_t  chosen;

	assign in_acc    = in_valid && !in_stall;
	assign extend_ok = node_count_q != '0 && !solved_q && attempt_q < budget_q &&
	                   node_count_q <= CNT_W'(MAX_NODES - 2);
	assign chosen    = ({1'b0, bias_draw} < goal_bias_q) ? goal_q
	                 : pt_t'{x: sample_x, y: sample_y, z: sample_z};

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= '0;
			attempt_q    <= '0;
			solved_q     <= 1'b0;
			trace_done_q <= 1'b0;
			trace_ptr_q  <= '0;
			scan_q       <= '0;
			out_valid_q  <= 1'b0;
			dv_go_q      <= 1'b0;
			sq_go_q      <= 1'b0;
			dist_go_q    <= 1'b0;
			wr_q         <= 1'b0;
		end else begin
			dv_go_q   <= 1'b0;
			sq_go_q   <= 1'b0;
			dist_go_q <= 1'b0;
			wr_q      <= 1'b0;
			// in the result state the hand-over below owns the output valid
			if (out_valid_q && !out_stall && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (kind_t'(kind))
							KIND_RESET: begin
								wr_q         <= 1'b1;
								waddr_q      <= '0;
								wdata_q      <= '{p: start_q, parent: '0, cost: '0};
								node_count_q <= CNT_W'(1);
								attempt_q    <= '0;
								trace_ptr_q  <= '0;
								solved_q     <= 1'b0;
								trace_done_q <= 1'b0;
								res_q        <= '{status: ST_RESET, idx: '0, p: start_q,
								                  cost: '0, last: 1'b0};
								state_q      <= S_RESULT;
							end
							KIND_EXTEND: begin
								if (extend_ok) begin
									attempt_q <= attempt_q + 1'b1;
									smp_q     <= chosen;
									pb_q      <= chosen;
									scan_q    <= '0;
									state_q   <= S_SCAN;
								end else begin
									res_q   <= '{status: ST_FAIL, default: '0};
									state_q <= S_RESULT;
								end
							end
							KIND_TRACE: begin
								if (solved_q && !trace_done_q) begin
									state_q <= S_TRACE_RD;
								end else begin
									res_q   <= '{status: ST_FAIL, default: '0};
									state_q <= S_RESULT;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_q < node_count_q) begin
						scan_q <= scan_q + 1'b1;
					end else if (!rd_v_q && !v_s2 && !v_s3) begin
						state_q <= S_NEAR_RD;
					end
				end
				S_NEAR_RD: begin
					state_q <= S_NEAR_WAIT;
				end
				S_NEAR_WAIT: begin
					nearp_q     <= ram_rd.p;
					base_cost_q <= ram_rd.cost;
					if (best_q <= SQ_W'(REACH_SQ)) begin
						// sample within one step: take it as is
						np_q        <= smp_q;
						pa_q        <= ram_rd.p;
						pb_q        <= smp_q;
						dist_go_q   <= 1'b1;
						dist_goal_q <= 1'b0;
						state_q     <= S_DIST_WAIT;
					end else begin
						sq_in_q <= best_q;
						sq_go_q <= 1'b1;
						state_q <= S_STEER_SQRT;
					end
				end
				S_STEER_SQRT: begin
					if (sq_done_q) begin
						d_q     <= sq_root;
						comp_q  <= 2'd0;
						dv_go_q <= 1'b1;
						state_q <= S_STEER_DIV;
					end
				end
				S_STEER_DIV: begin
					if (dv_done_q) begin
						case (comp_q)
							2'd0: begin
								np_q.x  <= div_res;
								comp_q  <= 2'd1;
								dv_go_q <= 1'b1;
							end
							2'd1: begin
								np_q.y  <= div_res;
								comp_q  <= 2'd2;
								dv_go_q <= 1'b1;
							end
							default: begin
								np_q.z      <= div_res[Z_W-1:0];
								pa_q        <= nearp_q;
								pb_q        <= '{x: np_q.x, y: np_q.y, z: div_res[Z_W-1:0]};
								dist_go_q   <= 1'b1;
								dist_goal_q <= 1'b0;
								state_q     <= S_DIST_WAIT;
							end
						endcase
					end
				end
				S_DIST_WAIT: begin
					if (v_s3) begin
						if (!dist_goal_q) begin
							sq_in_q <= dsum;
							sq_go_q <= 1'b1;
							state_q <= S_COST_SQRT;
						end else if (dsum <= SQ_W'(REACH_SQ)) begin
							sq_in_q <= dsum;
							sq_go_q <= 1'b1;
							state_q <= S_GOAL_SQRT;
						end else begin
							res_q   <= '{status: ST_ADDED, idx: idx_q, p: np_q,
							            cost: ncost_q, last: 1'b0};
							state_q <= S_RESULT;
						end
					end
				end
				S_COST_SQRT: begin
					if (sq_done_q) begin
						ncost_q     <= cost_sat(base_cost_q, sq_root);
						seg_a_q     <= nearp_q;
						seg_b_q     <= np_q;
						seg_steps_q <= steps_of(sq_root);
						seg_i_q     <= '0;
						seg_goal_q  <= 1'b0;
						comp_q      <= 2'd0;
						dv_go_q     <= 1'b1;
						state_q     <= S_SEG_DIV;
					end
				end
				S_GOAL_SQRT: begin
					if (sq_done_q) begin
						g_q         <= sq_root;
						seg_a_q     <= np_q;
						seg_b_q     <= goal_q;
						seg_steps_q <= steps_of(sq_root);
						seg_i_q     <= '0;
						seg_goal_q  <= 1'b1;
						comp_q      <= 2'd0;
						dv_go_q     <= 1'b1;
						state_q     <= S_SEG_DIV;
					end
				end
				S_SEG_DIV: begin
					if (dv_done_q) begin
						case (comp_q)
							2'd0: begin
								pt_q.x  <= div_res;
								comp_q  <= 2'd1;
								dv_go_q <= 1'b1;
							end
							2'd1: begin
								pt_q.y  <= div_res;
								comp_q  <= 2'd2;
								dv_go_q <= 1'b1;
							end
							default: begin
								pt_q.z  <= div_res[Z_W-1:0];
								state_q <= S_SEG_CHK;
							end
						endcase
					end
				end
				S_SEG_CHK: begin
					if (in_any_box(pt_q)) begin
						// blocked: a blocked first segment rejects, a blocked goal leg
						// still keeps the new node
						if (!seg_goal_q) begin
							res_q <= '{status: ST_REJECT, idx: near_q, p: np_q,
							          cost: ncost_q, last: 1'b0};
						end else begin
							res_q <= '{status: ST_ADDED, idx: idx_q, p: np_q,
							          cost: ncost_q, last: 1'b0};
						end
						state_q <= S_RESULT;
					end else if (seg_i_q != seg_steps_q) begin
						seg_i_q <= seg_i_q + 1'b1;
						comp_q  <= 2'd0;
						dv_go_q <= 1'b1;
						state_q <= S_SEG_DIV;
					end else if (!seg_goal_q) begin
						wr_q         <= 1'b1;
						waddr_q      <= node_count_q[IDX_W-1:0];
						wdata_q      <= '{p: np_q, parent: near_q, cost: ncost_q};
						idx_q        <= node_count_q[IDX_W-1:0];
						node_count_q <= node_count_q + 1'b1;
						pa_q         <= np_q;
						pb_q         <= goal_q;
						dist_go_q    <= 1'b1;
						dist_goal_q  <= 1'b1;
						state_q      <= S_DIST_WAIT;
					end else begin
						wr_q         <= 1'b1;
						waddr_q      <= idx_q + 1'b1;
						wdata_q      <= '{p: goal_q, parent: idx_q, cost: cost_sat(ncost_q, g_q)};
						node_count_q <= node_count_q + 1'b1;
						solved_q     <= 1'b1;
						trace_done_q <= 1'b0;
						trace_ptr_q  <= idx_q + 1'b1;
						res_q        <= '{status: ST_GOAL, idx: idx_q + 1'b1, p: goal_q,
						                  cost: cost_sat(ncost_q, g_q), last: 1'b0};
						state_q      <= S_RESULT;
					end
				end
				S_TRACE_RD: begin
					state_q <= S_TRACE_WAIT;
				end
				S_TRACE_WAIT: begin
					res_q <= '{status: ST_WAYPT, idx: trace_ptr_q, p: ram_rd.p,
					          cost: ram_rd.cost, last: trace_ptr_q == '0};
					if (trace_ptr_q == '0) begin
						trace_done_q <= 1'b1;
					end else begin
						trace_ptr_q <= ram_rd.parent;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					// hand over once the output register is free or being emptied
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall      = state_q != S_IDLE;
	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign node_index    = out_q.idx;
	assign node_x        = out_q.p.x;
	assign node_y        = out_q.p.y;
	assign node_z        = out_q.p.z;
	assign path_cost     = out_q.cost;
	assign last_waypoint = out_q.last;

	// tree never grows past the store
	`RRT_ASSERT_IMP(a_count_bound, 1'b1, node_count_q <= CNT_W'(MAX_NODES), "node count overflow")
	// a solved tree holds at least the start and the goal
	`RRT_ASSERT_IMP(a_solved_nodes, solved_q, node_count_q >= CNT_W'(2), "solved with too few nodes")
	// the trace walk only visits stored nodes
	`RRT_ASSERT_IMP(a_trace_in_tree, solved_q && !trace_done_q,
		{1'b0, trace_ptr_q} < node_count_q, "trace pointer outside tree")
	// a division is never launched on top of a running one
	`RRT_ASSERT_IMP(a_div_overlap, dv_go_q, !dv_busy_q, "divider restarted while busy")
	// a root request always starts the square root
	`RRT_ASSERT_NXT(a_sqrt_start, sq_go_q, sq_busy_q, "square root did not start")

endmodule

/* dv/rrt_tree_extend_3d_core_tb.sv */
// self-checking testbench for rrt_tree_extend_3d_core: directed and random extend/trace beats
// depends on rrt3d_pkg and the core rtl; holds its own tree predictor in a scoreboard class
module rrt_tree_extend_3d_core_tb;
	import rrt3d_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t     st;
		int          idx;
		int          x;
		int          y;
		int          z;
		int          cost;
		bit          last;
	} waypoint_t;

	// tree predictor plus the queue of results still owed by the core
	class tree_scoreboard;
		int        px[MAX_NODES];
		int        py[MAX_NODES];
		int        pz[MAX_NODES];
		int        parent[MAX_NODES];
		int        cost[MAX_NODES];
		int        nodes;
		int        attempts;
		int        trace_ptr;
		bit        solved;
		bit        trace_over;
		int        cfg[8];
		waypoint_t owed[$];
		int        errors;
		int        seen[6];

		function void clear();
			cfg = '{1280, 1280, 1280, 23040, 23040, 5120, 6554, 3000};
			nodes = 0; attempts = 0; trace_ptr = 0; solved = 0; trace_over = 0;
			errors = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function longint unsigned dsq(longint ax, longint ay, longint az,
		                              longint bx, longint by, longint bz);
			return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) + (az - bz) * (az - bz);
		endfunction

		function bit hits_box(longint x, longint y, longint z);
			bit h;
			h = 0;
			for (int b = 0; b < NUM_BOXES; b++)
				if (x >= BOX_M[b][0] * ONE_M - INFLATE && x <= BOX_M[b][3] * ONE_M + INFLATE &&
				    y >= BOX_M[b][1] * ONE_M - INFLATE && y <= BOX_M[b][4] * ONE_M + INFLATE &&
				    z >= BOX_M[b][2] * ONE_M - INFLATE && z <= BOX_M[b][5] * ONE_M + INFLATE)
					h = 1;
			return h;
		endfunction

		// sampled segment test, sample spacing half a metre, clamped
		function bit clear_path(longint ax, longint ay, longint az,
		                        longint bx, longint by, longint bz);
			longint n;
			n = longint'(root(dsq(ax, ay, az, bx, by, bz))) >>> (FRAC_BITS - 1);
			if (n < 2) n = 2;
			if (n > MAX_SEGMENT_SAMPLES - 1) n = MAX_SEGMENT_SAMPLES - 1;
			for (longint i = 0; i <= n; i++)
				if (hits_box(ax + (bx - ax) * i / n, ay + (by - ay) * i / n,
				             az + (bz - az) * i / n))
					return 0;
			return 1;
		endfunction

		function int add_cost(int c, longint unsigned d);
			longint unsigned s;
			s = longint'(c) + d;
			return (s > 24'hFFFFFF) ? 24'hFFFFFF : int'(s);
		endfunction

		function void owe(status_t st, int idx, longint x, longint y, longint z, int c, bit l);
			waypoint_t w;
			w.st = st; w.idx = idx & 12'hFFF; w.x = x & 15'h7FFF; w.y = y & 15'h7FFF;
			w.z = z & 13'h1FFF; w.cost = c & 24'hFFFFFF; w.last = l;
			owed = {owed, w};
		endfunction

		function void note(kind_t k, int sx, int sy, int sz, int bias);
			longint tx, ty, tz, nx, ny, nz, qx, qy, qz, d;
			longint unsigned best, d2;
			int near, id, nc, gc;
			case (k)
				KIND_RESET: begin
					px[0] = cfg[CFG_START_X]; py[0] = cfg[CFG_START_Y];
					pz[0] = cfg[CFG_START_Z]; parent[0] = 0; cost[0] = 0;
					nodes = 1; attempts = 0; trace_ptr = 0; solved = 0; trace_over = 0;
					owe(ST_RESET, 0, px[0], py[0], pz[0], 0, 0);
				end
				KIND_EXTEND: begin
					if (nodes == 0 || solved || attempts >= cfg[CFG_BUDGET] ||
					    nodes + 2 > MAX_NODES) begin
						owe(ST_FAIL, 0, 0, 0, 0, 0, 0);
						return;
					end
					attempts++;
					if (bias < cfg[CFG_BIAS]) begin
						tx = cfg[CFG_GOAL_X]; ty = cfg[CFG_GOAL_Y]; tz = cfg[CFG_GOAL_Z];
					end else begin
						tx = sx; ty = sy; tz = sz;
					end
					near = 0;
					best = dsq(px[0], py[0], pz[0], tx, ty, tz);
					for (int i = 1; i < nodes; i++) begin
						d2 = dsq(px[i], py[i], pz[i], tx, ty, tz);
						if (d2 < best) begin
							best = d2; near = i;
						end
					end
					nx = px[near]; ny = py[near]; nz = pz[near];
					if (best <= REACH_SQ) begin
						qx = tx; qy = ty; qz = tz;
					end else begin
						d = longint'(root(best));
						qx = nx + (tx - nx) * STEP_LEN / d;
						qy = ny + (ty - ny) * STEP_LEN / d;
						qz = nz + (tz - nz) * STEP_LEN / d;
					end
					nc = add_cost(cost[near], root(dsq(nx, ny, nz, qx, qy, qz)));
					if (!clear_path(nx, ny, nz, qx, qy, qz)) begin
						owe(ST_REJECT, near, qx, qy, qz, nc, 0);
						return;
					end
					id = nodes;
					px[id] = qx; py[id] = qy; pz[id] = qz; parent[id] = near; cost[id] = nc;
					nodes++;
					tx = cfg[CFG_GOAL_X]; ty = cfg[CFG_GOAL_Y]; tz = cfg[CFG_GOAL_Z];
					d2 = dsq(qx, qy, qz, tx, ty, tz);
					if (d2 <= REACH_SQ && clear_path(qx, qy, qz, tx, ty, tz)) begin
						gc = add_cost(nc, root(d2));
						px[id+1] = tx; py[id+1] = ty; pz[id+1] = tz;
						parent[id+1] = id; cost[id+1] = gc;
						nodes++;
						solved = 1; trace_over = 0; trace_ptr = id + 1;
						owe(ST_GOAL, id + 1, tx, ty, tz, gc, 0);
					end else begin
						owe(ST_ADDED, id, qx, qy, qz, nc, 0);
					end
				end
				KIND_TRACE: begin
					if (!solved || trace_over) begin
						owe(ST_FAIL, 0, 0, 0, 0, 0, 0);
						return;
					end
					id = trace_ptr;
					owe(ST_WAYPT, id, px[id], py[id], pz[id], cost[id], id == 0);
					if (id == 0) trace_over = 1;
					else trace_ptr = parent[id];
				end
				default: ;
			endcase
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
		endtask

		task check(int st, int idx, int x, int y, int z, int c, bit l);
			waypoint_t w;
			if (owed.size() == 0) begin
				report("unexpected result beat, status", st, -1);
				return;
			end
			w = owed.pop_front();
			if (st < 6) seen[st]++;
			if (st != int'(w.st)) report("status", st, w.st);
			if (idx != w.idx) report("node_index", idx, w.idx);
			if (x != w.x) report("node_x", x, w.x);
			if (y != w.y) report("node_y", y, w.y);
			if (z != w.z) report("node_z", z, w.z);
			if (c != w.cost) report("path_cost", c, w.cost);
			if (l != w.last) report("last_waypoint", l, w.last);
		endtask
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_we = 0;
	logic [2:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 0;
	logic              in_stall;
	logic [1:0]        kind = '0;
	logic [X_W-1:0]    sample_x = '0;
	logic [X_W-1:0]    sample_y = '0;
	logic [Z_W-1:0]    sample_z = '0;
	logic [BIAS_W-1:0] bias_draw = '0;
	logic              out_valid;
	logic              out_stall = 0;
	logic [2:0]        status;
	logic [IDX_W-1:0]  node_index;
	logic [X_W-1:0]    node_x;
	logic [X_W-1:0]    node_y;
	logic [Z_W-1:0]    node_z;
	logic [COST_W-1:0] path_cost;
	logic              last_waypoint;

	tree_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int beats_sent = 0;
	int quiet_cycles = 0;

	// watchdog limit on quiet cycles, and the settle pause used by drain
	localparam int QUIET_LIMIT = 60000;
	localparam int SETTLE = 3000;

	rrt_tree_extend_3d_core uut (.*);

	always #2 clk = ~clk;

	// result side: random stall, changed at the falling edge
	always @(negedge clk)
		out_stall = ($urandom_range(99) < recv_stall_pct);

	// every accepted result beat goes straight to the scoreboard
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check(status, node_index, node_x, node_y, node_z, path_cost, last_waypoint);

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// idling mode rotates every 20 beats: none, sender, receiver, both
	task automatic pick_idling();
		case ((beats_sent / 20) % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
			default: begin send_idle_pct = 30; recv_stall_pct = 30; end
		endcase
	endtask

	// one input beat, held until taken; called at a falling edge
	task automatic send_beat(kind_t k, int sx, int sy, int sz, int bias);
		pick_idling();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		kind = k; sample_x = sx; sample_y = sy; sample_z = sz; bias_draw = bias;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		sb.note(k, sx, sy, sz, bias);
		beats_sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	// pause the sender until every owed result is back and the core has gone quiet
	task automatic drain();
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t r, int v);
		cfg_we = 1; cfg_index = r; cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
		sb.cfg[r] = v;
	endtask

	task automatic write_all(int sx, int sy, int sz, int gx, int gy, int gz, int b, int n);
		write_reg(CFG_START_X, sx); write_reg(CFG_START_Y, sy); write_reg(CFG_START_Z, sz);
		write_reg(CFG_GOAL_X, gx);  write_reg(CFG_GOAL_Y, gy);  write_reg(CFG_GOAL_Z, gz);
		write_reg(CFG_BIAS, b);     write_reg(CFG_BUDGET, n);
	endtask

	function automatic int near_goal(int g, int hi);
		int v;
		v = g + $urandom_range(8 * ONE_M) - 4 * ONE_M;
		return (v < 0) ? 0 : (v > hi) ? hi : v;
	endfunction

	// reset, a run of extends, about half aimed loosely at the goal, then traces to the root
	task automatic tree_run(int n_ext);
		int cnt;
		send_beat(KIND_RESET, $urandom_range(25600), $urandom_range(25600),
		          $urandom_range(7680), $urandom_range(65535));
		for (int i = 0; i < n_ext; i++) begin
			if ($urandom_range(99) < 50)
				send_beat(KIND_EXTEND, near_goal(sb.cfg[CFG_GOAL_X], 25600),
				          near_goal(sb.cfg[CFG_GOAL_Y], 25600),
				          near_goal(sb.cfg[CFG_GOAL_Z], 7680), $urandom_range(65535));
			else
				send_beat(KIND_EXTEND, $urandom_range(25600), $urandom_range(25600),
				          $urandom_range(7680), $urandom_range(65535));
		end
		// walk the path while the predictor has one, plus one beat past the root
		cnt = 0;
		while (sb.solved && !sb.trace_over && cnt < 40) begin
			send_beat(KIND_TRACE, $urandom_range(25600), $urandom_range(25600),
			          $urandom_range(7680), $urandom_range(65535));
			cnt++;
		end
		send_beat(KIND_TRACE, 0, 0, 0, 0);
	endtask

	// noise: any kind, the unknown one included
	task automatic noise_beat();
		send_beat(kind_t'($urandom_range(3)), $urandom_range(25600), $urandom_range(25600),
		          $urandom_range(7680), $urandom_range(65535));
	endtask

	initial begin
		int gx, gy, gz;
		sb.clear();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: no tree yet, unknown kind, then the field extremes on the default setup
		send_beat(KIND_EXTEND, 100, 100, 100, 65535);
		send_beat(KIND_TRACE, 0, 0, 0, 0);
		send_beat(kind_t'(2'd3), 25600, 25600, 7680, 65535);
		send_beat(KIND_RESET, 0, 0, 0, 0);
		send_beat(KIND_EXTEND, 0, 0, 0, 65535);
		send_beat(KIND_EXTEND, 25600, 25600, 7680, 65535);
		send_beat(KIND_EXTEND, 25600, 0, 7680, 0);
		send_beat(KIND_EXTEND, 7680, 7680, 1280, 65535);
		send_beat(KIND_TRACE, 0, 0, 0, 0);
		drain();

		// start right beside the goal: solved on the first beat, then a full trace
		write_all(22000, 22000, 5120, 23040, 23040, 5120, 65536, 4094);
		send_beat(KIND_RESET, 0, 0, 0, 0);
		send_beat(KIND_EXTEND, 0, 0, 0, 65535);
		send_beat(KIND_EXTEND, 0, 0, 0, 0);
		repeat (4) send_beat(KIND_TRACE, 25600, 25600, 7680, 65535);
		send_beat(KIND_RESET, 0, 0, 0, 0);
		drain();

		// budget of one attempt and a bias that never picks the goal
		write_all(0, 0, 0, 25600, 25600, 7680, 0, 1);
		send_beat(KIND_RESET, 0, 0, 0, 0);
		send_beat(KIND_EXTEND, 1000, 1000, 500, 0);
		send_beat(KIND_EXTEND, 1000, 1000, 500, 0);
		send_beat(KIND_EXTEND, 25600, 25600, 7680, 0);
		drain();

		// random part: each phase draws a fresh start and goal, mostly close together
		while (beats_sent < 125) begin
			gx = $urandom_range(25600); gy = $urandom_range(25600); gz = $urandom_range(7680);
			write_all(near_goal(gx, 25600) / 2 + gx / 2 * (($urandom_range(3) == 0) ? 0 : 1),
			          near_goal(gy, 25600), near_goal(gz, 7680), gx, gy, gz,
			          $urandom_range(65536), $urandom_range(3) == 0 ? $urandom_range(1, 6)
			                                                          : $urandom_range(1, 4094));
			repeat (4) begin
				if ($urandom_range(99) < 80) tree_run($urandom_range(1, 12));
				else repeat (3) noise_beat();
			end
			drain();
		end

		$display("%0d input beats; results: %0d rejected, %0d added, %0d goal, %0d fail, %0d waypoint",
		         beats_sent, sb.seen[ST_REJECT], sb.seen[ST_ADDED], sb.seen[ST_GOAL],
		         sb.seen[ST_FAIL], sb.seen[ST_WAYPT]);
		$display("%0d tree resets across directed, extreme and random start/goal settings",
		         sb.seen[ST_RESET]);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results never seen", sb.errors, sb.owed.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
